// ----- rtl/core/cie_pkg.sv -----
// Shared types, constants and the pair rule for the concordance index engine.
// Used by cie_ctrl, cie_dp and concordance_index_engine; no dependencies.
package cie_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int SCORE_W   = 32;
    localparam int TIME_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int MODE_W    = 2;
    localparam int PAIRS_W   = 19;
    localparam int HALVES_W  = 20;
    localparam int Q16_W     = 17;
    localparam int NUM_W     = HALVES_W + 16;
    localparam int DEN_W     = PAIRS_W + 1;
    localparam int DIV_STEPS = Q16_W;
    localparam int DIVCNT_W  = $clog2(DIV_STEPS + 1);
    localparam int ENTRY_W   = SCORE_W + STATUS_W + TIME_W;

    // Outcome modes
    localparam logic [MODE_W-1:0] MODE_BINARY    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SURVIVAL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPETING = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_CENSORED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EVENT     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_COMPETING = 2'd2;

    // Pair rule outcomes
    localparam logic [1:0] RULE_NONE   = 2'd0;
    localparam logic [1:0] RULE_I_WINS = 2'd1;
    localparam logic [1:0] RULE_J_WINS = 2'd2;

    // Half-unit credits
    localparam logic [1:0] CREDIT_NONE = 2'd0;
    localparam logic [1:0] CREDIT_TIE  = 2'd1;
    localparam logic [1:0] CREDIT_WIN  = 2'd2;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              eval;
        logic              lat_i;
        logic              clr_acc;
        logic              div_start;
        logic              out_load;
        logic              ovf;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_full;
    } t_dp_sts;

    // Decide which item of a pair must hold the higher score
    function automatic logic [1:0] pair_rule(
        input logic [MODE_W-1:0]   mode,
        input logic [STATUS_W-1:0] si,
        input logic [STATUS_W-1:0] sj,
        input logic                earlier
    );
        logic [1:0] r;
        r = RULE_NONE;
        case (mode)
            MODE_BINARY: begin
                if (si == ST_EVENT && sj == ST_CENSORED) r = RULE_I_WINS;
                else if (si == ST_CENSORED && sj == ST_EVENT) r = RULE_J_WINS;
            end
            MODE_SURVIVAL: begin
                if (earlier) begin
                    if (si == ST_EVENT && (sj inside {ST_CENSORED, ST_EVENT}))
                        r = RULE_I_WINS;
                end else begin
                    if (si == ST_EVENT && sj == ST_CENSORED) r = RULE_I_WINS;
                    else if (si == ST_CENSORED && sj == ST_EVENT) r = RULE_J_WINS;
                end
            end
            MODE_COMPETING: begin
                if (earlier) begin
                    if (si == ST_EVENT && (sj inside {ST_CENSORED, ST_EVENT, ST_COMPETING}))
                        r = RULE_I_WINS;
                    else if (si == ST_COMPETING && sj == ST_EVENT)
                        r = RULE_J_WINS;
                end else begin
                    if (si == ST_EVENT && (sj inside {ST_CENSORED, ST_COMPETING}))
                        r = RULE_I_WINS;
                    else if ((si inside {ST_COMPETING, ST_CENSORED}) && sj == ST_EVENT)
                        r = RULE_J_WINS;
                end
            end
            default: r = RULE_NONE;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/cie_ctrl.sv -----
// Controller for the concordance index engine: loading, pair sweep, division.
// Depends on cie_pkg; drives cie_dp through t_dp_cmd and reads t_dp_sts.
module cie_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_last_item,
    output logic                 o_in_ready,
    output cie_pkg::t_dp_cmd     o_cmd,
    input  cie_pkg::t_dp_sts     i_sts
);

    localparam logic [2:0] S_LOAD     = 3'd0;
    localparam logic [2:0] S_RD_I     = 3'd1;
    localparam logic [2:0] S_LAT_I    = 3'd2;
    localparam logic [2:0] S_SWEEP    = 3'd3;
    localparam logic [2:0] S_DRAIN    = 3'd4;
    localparam logic [2:0] S_DIV_GO   = 3'd5;
    localparam logic [2:0] S_DIV_WAIT = 3'd6;

    logic [2:0]                  r_state, n_state;
    logic [cie_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [cie_pkg::ADDR_W-1:0]  r_i, n_i;
    logic [cie_pkg::ADDR_W-1:0]  r_j, n_j;
    logic                        r_ovf, n_ovf;
    logic                        r_drain, n_drain;

    logic                        w_accept;
    logic                        w_room;
    logic [cie_pkg::CNT_W-1:0]   w_cnt_after;
    logic [cie_pkg::CNT_W-1:0]   w_last_idx;
    logic [cie_pkg::CNT_W-1:0]   w_j_ext;
    logic [cie_pkg::CNT_W-1:0]   w_i_next_ext;

    assign o_in_ready   = (r_state == S_LOAD);
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_room       = (r_cnt < cie_pkg::CNT_W'(cie_pkg::MAX_ITEMS));
    assign w_cnt_after  = r_cnt + cie_pkg::CNT_W'(w_room);
    assign w_last_idx   = r_cnt - cie_pkg::CNT_W'(1);
    assign w_j_ext      = {1'b0, r_j};
    assign w_i_next_ext = {1'b0, r_i} + cie_pkg::CNT_W'(1);

    // Sequence loading, the pair sweep and the final division
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_j     = r_j;
        n_ovf   = r_ovf;
        n_drain = r_drain;
        o_cmd   = '0;
        o_cmd.ovf     = r_ovf;
        o_cmd.wr_addr = r_cnt[cie_pkg::ADDR_W-1:0];
        case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    o_cmd.wr_en = w_room;
                    n_cnt       = w_cnt_after;
                    if (!w_room) n_ovf = 1'b1;
                    if (i_last_item) begin
                        o_cmd.clr_acc = 1'b1;
                        n_i     = '0;
                        n_drain = 1'b0;
                        if (w_cnt_after < cie_pkg::CNT_W'(2)) n_state = S_DRAIN;
                        else n_state = S_RD_I;
                    end
                end
            end
            S_RD_I: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_i;
                n_state       = S_LAT_I;
            end
            S_LAT_I: begin
                o_cmd.lat_i = 1'b1;
                n_j         = r_i + cie_pkg::ADDR_W'(1);
                n_state     = S_SWEEP;
            end
            S_SWEEP: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_j;
                o_cmd.eval    = 1'b1;
                if (w_j_ext == w_last_idx) begin
                    if (w_i_next_ext == w_last_idx) begin
                        n_drain = 1'b0;
                        n_state = S_DRAIN;
                    end else begin
                        n_i     = r_i + cie_pkg::ADDR_W'(1);
                        n_state = S_RD_I;
                    end
                end else begin
                    n_j = r_j + cie_pkg::ADDR_W'(1);
                end
            end
            S_DRAIN: begin
                // wait for the compare and accumulate stages to empty
                n_drain = 1'b1;
                if (r_drain) n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!i_sts.div_busy && !i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_ovf   <= 1'b0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
            r_ovf   <= n_ovf;
            r_drain <= n_drain;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= cie_pkg::CNT_W'(cie_pkg::MAX_ITEMS))
        else $error("item count above capacity");

    a_sweep_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> ((r_j > r_i) && (w_j_ext < r_cnt)))
        else $error("sweep index out of order");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last_item) |=> !o_in_ready)
        else $error("input still taken after the closing transaction");

endmodule

// ----- rtl/core/cie_dp.sv -----
// Datapath for the concordance index engine: item store, pair compare,
// accumulators, restoring divider and result register. Depends on cie_pkg.
module cie_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [cie_pkg::MODE_W-1:0]      i_cfg_wr_data,
    input  logic [cie_pkg::SCORE_W-1:0]     i_score,
    input  logic [cie_pkg::STATUS_W-1:0]    i_status,
    input  logic [cie_pkg::TIME_W-1:0]      i_event_time,
    input  cie_pkg::t_dp_cmd                i_cmd,
    output cie_pkg::t_dp_sts                o_sts,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [cie_pkg::PAIRS_W-1:0]     o_pair_count,
    output logic [cie_pkg::HALVES_W-1:0]    o_concordant_halves,
    output logic [cie_pkg::Q16_W-1:0]       o_concordance_q16,
    output logic                            o_no_pairs,
    output logic                            o_overflowed
);

    logic [cie_pkg::ENTRY_W-1:0]   mem [cie_pkg::MAX_ITEMS];
    logic [cie_pkg::ENTRY_W-1:0]   r_mem_q;

    logic [cie_pkg::MODE_W-1:0]    r_mode;
    logic [cie_pkg::SCORE_W-1:0]   r_i_score;
    logic [cie_pkg::STATUS_W-1:0]  r_i_status;
    logic [cie_pkg::TIME_W-1:0]    r_i_time;

    logic                          r_ev_v;
    logic                          r_acc_v;
    logic                          r_hit;
    logic [1:0]                    r_add;
    logic [cie_pkg::PAIRS_W-1:0]   r_pairs;
    logic [cie_pkg::HALVES_W-1:0]  r_halves;

    logic                          r_div_busy;
    logic [cie_pkg::DIVCNT_W-1:0]  r_div_cnt;
    logic [cie_pkg::DEN_W-1:0]     r_rem;
    logic [cie_pkg::DEN_W-1:0]     r_den;
    logic [cie_pkg::Q16_W-1:0]     r_quo;

    logic                          r_out_valid;
    logic [cie_pkg::PAIRS_W-1:0]   r_out_pairs;
    logic [cie_pkg::HALVES_W-1:0]  r_out_halves;
    logic [cie_pkg::Q16_W-1:0]     r_out_q16;
    logic                          r_out_none;
    logic                          r_out_ovf;

    logic [cie_pkg::SCORE_W-1:0]   w_q_score;
    logic [cie_pkg::STATUS_W-1:0]  w_q_status;
    logic [cie_pkg::TIME_W-1:0]    w_q_time;
    logic [1:0]                    w_rule;
    logic [1:0]                    w_credit;
    logic [cie_pkg::NUM_W-1:0]     w_num;
    logic [cie_pkg::DEN_W:0]       w_trial;
    logic                          w_fits;

    assign {w_q_score, w_q_status, w_q_time} = r_mem_q;

    // Latch the outcome mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= cie_pkg::MODE_BINARY;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    // Item store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_cmd.wr_addr] <= {i_score, i_status, i_event_time};
        end
        if (i_cmd.rd_en) begin
            r_mem_q <= mem[i_cmd.rd_addr];
        end
    end

    // Hold the outer item of the sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_i) begin
            r_i_score  <= w_q_score;
            r_i_status <= w_q_status;
            r_i_time   <= w_q_time;
        end
    end

    // Classify the pair and grade the scores
    always_comb begin
        w_rule   = cie_pkg::pair_rule(r_mode, r_i_status, w_q_status, r_i_time < w_q_time);
        w_credit = cie_pkg::CREDIT_NONE;
        if (r_i_score == w_q_score) begin
            w_credit = cie_pkg::CREDIT_TIE;
        end else if (w_rule == cie_pkg::RULE_I_WINS && r_i_score > w_q_score) begin
            w_credit = cie_pkg::CREDIT_WIN;
        end else if (w_rule == cie_pkg::RULE_J_WINS && w_q_score > r_i_score) begin
            w_credit = cie_pkg::CREDIT_WIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_v  <= 1'b0;
            r_acc_v <= 1'b0;
        end else begin
            r_ev_v  <= i_cmd.eval;
            r_acc_v <= r_ev_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= (w_rule != cie_pkg::RULE_NONE);
        r_add <= (w_rule != cie_pkg::RULE_NONE) ? w_credit : cie_pkg::CREDIT_NONE;
    end

    // Accumulate pair count and concordant halves
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_acc) begin
            r_pairs  <= '0;
            r_halves <= '0;
        end else if (r_acc_v) begin
            r_pairs  <= r_pairs + cie_pkg::PAIRS_W'(r_hit);
            r_halves <= r_halves + cie_pkg::HALVES_W'(r_add);
        end
    end

    // Restoring division of (halves*65536 + pairs) by 2*pairs, one bit a cycle
    assign w_num   = {r_halves, 16'b0} + cie_pkg::NUM_W'(r_pairs);
    assign w_trial = {r_rem, r_quo[cie_pkg::Q16_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
        end else if (i_cmd.div_start) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= cie_pkg::DIVCNT_W'(cie_pkg::DIV_STEPS);
        end else if (r_div_busy) begin
            r_div_cnt <= r_div_cnt - cie_pkg::DIVCNT_W'(1);
            if (r_div_cnt == cie_pkg::DIVCNT_W'(1)) r_div_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= {1'b0, w_num[cie_pkg::NUM_W-1:cie_pkg::Q16_W]};
            r_quo <= w_num[cie_pkg::Q16_W-1:0];
            r_den <= {r_pairs, 1'b0};
        end else if (r_div_busy) begin
            r_rem <= w_fits ? cie_pkg::DEN_W'(w_trial - {1'b0, r_den})
                            : w_trial[cie_pkg::DEN_W-1:0];
            r_quo <= {r_quo[cie_pkg::Q16_W-2:0], w_fits};
        end
    end

    // Result register: load once, drop on the output transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_pairs  <= r_pairs;
            r_out_halves <= r_halves;
            r_out_none   <= (r_pairs == '0);
            r_out_q16    <= (r_pairs == '0) ? '0 : r_quo;
            r_out_ovf    <= i_cmd.ovf;
        end
    end

    assign o_sts.div_busy    = r_div_busy;
    assign o_sts.out_full    = r_out_valid;
    assign o_out_valid         = r_out_valid;
    assign o_pair_count        = r_out_pairs;
    assign o_concordant_halves = r_out_halves;
    assign o_concordance_q16   = r_out_q16;
    assign o_no_pairs          = r_out_none;
    assign o_overflowed        = r_out_ovf;

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !r_div_busy)
        else $error("division restarted while busy");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid)
        else $error("result overwritten before its transaction");

    a_acc_quiet_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_busy |-> !r_acc_v)
        else $error("accumulator moved during division");

endmodule

// ----- rtl/core/concordance_index_engine.sv -----
// Top level of the concordance index engine (Harrell's C over a loaded set).
// Depends on cie_pkg, cie_ctrl and cie_dp.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+---------------------------------------
//   input    | i_in_valid / o_in_ready      | i_score, i_status, i_event_time, i_last_item
//   output   | o_out_valid / i_out_ready    | o_pair_count, o_concordant_halves,
//            |                              | o_concordance_q16, o_no_pairs, o_overflowed
//   config   | i_cfg_wr_en (no wait)        | i_cfg_wr_data (outcome mode)
//
// Loading accepts one item per cycle. After the closing item the sweep reads the
// item store once per pair and once per outer item, then the compare and
// accumulate stages drain, the divider starts and forms one quotient bit per
// cycle, and the result register loads.
// Reset (synchronous, active low) empties the set and clears the mode to binary.
// Input stalls during sweep, drain and division; a pending result holds in its
// register while the next set loads, and the next result load waits until it is taken.
module concordance_index_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [cie_pkg::MODE_W-1:0]      i_cfg_wr_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [cie_pkg::SCORE_W-1:0]     i_score,
    input  logic [cie_pkg::STATUS_W-1:0]    i_status,
    input  logic [cie_pkg::TIME_W-1:0]      i_event_time,
    input  logic                            i_last_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [cie_pkg::PAIRS_W-1:0]     o_pair_count,
    output logic [cie_pkg::HALVES_W-1:0]    o_concordant_halves,
    output logic [cie_pkg::Q16_W-1:0]       o_concordance_q16,
    output logic                            o_no_pairs,
    output logic                            o_overflowed
);

    cie_pkg::t_dp_cmd w_cmd;
    cie_pkg::t_dp_sts w_sts;

    cie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_item (i_last_item),
        .o_in_ready  (o_in_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    cie_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_score             (i_score),
        .i_status            (i_status),
        .i_event_time        (i_event_time),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_out_ready         (i_out_ready),
        .o_out_valid         (o_out_valid),
        .o_pair_count        (o_pair_count),
        .o_concordant_halves (o_concordant_halves),
        .o_concordance_q16   (o_concordance_q16),
        .o_no_pairs          (o_no_pairs),
        .o_overflowed        (o_overflowed)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for concordance_index_engine: directed table, then random sets.
// Predicts untyped results in SystemVerilog, takes typed ones from the table, checks all.
// Depends on cie_pkg and the concordance_index_engine RTL.
module testbench;

    localparam logic [cie_pkg::MODE_W-1:0]   MODE_UNUSED   = 2'd3;
    localparam logic [cie_pkg::STATUS_W-1:0] STATUS_BAD    = 2'd3;
    localparam int                           DIRECTED_ROWS = 21;
    localparam int                           SETTLE_CYCLES = 64;
    localparam int                           HOLD_CYCLES   = 3000;
    localparam int                           HOLD_SETS     = 3;
    localparam int                           BIG_SET_ITEMS = cie_pkg::MAX_ITEMS + 2;
    localparam logic [cie_pkg::PAIRS_W-1:0]  PAIRS_SAT     = '1;
    localparam logic [cie_pkg::HALVES_W-1:0] HALVES_SAT    = '1;

    typedef struct packed {
        logic [cie_pkg::SCORE_W-1:0]  score;
        logic [cie_pkg::STATUS_W-1:0] status;
        logic [cie_pkg::TIME_W-1:0]   stamp;
        logic                         last;
    } t_item;

    typedef struct packed {
        logic [cie_pkg::PAIRS_W-1:0]  pairs;
        logic [cie_pkg::HALVES_W-1:0] halves;
        logic [cie_pkg::Q16_W-1:0]    q16;
        logic                         no_pairs;
        logic                         ovf;
    } t_tally;

    typedef struct packed {
        logic [cie_pkg::MODE_W-1:0] mode;
        t_item                      item;
        logic                       typed;
        t_tally                     want;
    } t_row;

    typedef enum logic [1:0] {ORDER_NONE, ORDER_FIRST, ORDER_SECOND} t_risk_order;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [cie_pkg::MODE_W-1:0]   cfg_wr_data = '0;
    logic                         in_valid    = 1'b0;
    logic [cie_pkg::SCORE_W-1:0]  in_score    = '0;
    logic [cie_pkg::STATUS_W-1:0] in_status   = '0;
    logic [cie_pkg::TIME_W-1:0]   in_stamp    = '0;
    logic                         in_last     = 1'b0;
    logic                         out_ready   = 1'b0;
    logic                         in_ready;
    logic                         out_valid;
    logic [cie_pkg::PAIRS_W-1:0]  out_pairs;
    logic [cie_pkg::HALVES_W-1:0] out_halves;
    logic [cie_pkg::Q16_W-1:0]    out_q16;
    logic                         out_no_pairs;
    logic                         out_ovf;

    // Predictor state: the set being loaded and the engine's outcome mode
    logic [cie_pkg::SCORE_W-1:0]  set_score  [cie_pkg::MAX_ITEMS];
    logic [cie_pkg::STATUS_W-1:0] set_status [cie_pkg::MAX_ITEMS];
    logic [cie_pkg::TIME_W-1:0]   set_stamp  [cie_pkg::MAX_ITEMS];
    int                           set_len     = 0;
    bit                           set_dropped = 1'b0;
    logic [cie_pkg::MODE_W-1:0]   eng_mode    = cie_pkg::MODE_BINARY;
    t_tally                       pending_tallies [$];
    int                           mismatches  = 0;

    // Idling controls and the receiver hold-off request
    int                  send_idle = 0;
    int                  recv_idle = 0;
    int                  hold_req  = 0;
    int                  hold_ack  = 0;
    int                  hold_left = 0;

    t_row                directed_rows [DIRECTED_ROWS];

    concordance_index_engine uut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_wr_data      (cfg_wr_data),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_score            (in_score),
        .i_status           (in_status),
        .i_event_time       (in_stamp),
        .i_last_item        (in_last),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_pair_count       (out_pairs),
        .o_concordant_halves(out_halves),
        .o_concordance_q16  (out_q16),
        .o_no_pairs         (out_no_pairs),
        .o_overflowed       (out_ovf)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #32000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Decide which item of a pair should carry the higher score
    function automatic t_risk_order rank_pair(input logic [cie_pkg::MODE_W-1:0] mode,
                                              input logic [cie_pkg::STATUS_W-1:0] a,
                                              input logic [cie_pkg::STATUS_W-1:0] b,
                                              input bit sooner);
        t_risk_order ord;
        ord = ORDER_NONE;
        if (mode == cie_pkg::MODE_BINARY) begin
            if (a == cie_pkg::ST_EVENT && b == cie_pkg::ST_CENSORED) ord = ORDER_FIRST;
            if (a == cie_pkg::ST_CENSORED && b == cie_pkg::ST_EVENT) ord = ORDER_SECOND;
        end else if (mode == cie_pkg::MODE_SURVIVAL) begin
            if (sooner) begin
                if (a == cie_pkg::ST_EVENT &&
                    (b == cie_pkg::ST_CENSORED || b == cie_pkg::ST_EVENT)) ord = ORDER_FIRST;
            end else begin
                if (a == cie_pkg::ST_EVENT && b == cie_pkg::ST_CENSORED) ord = ORDER_FIRST;
                if (a == cie_pkg::ST_CENSORED && b == cie_pkg::ST_EVENT) ord = ORDER_SECOND;
            end
        end else if (mode == cie_pkg::MODE_COMPETING) begin
            if (sooner) begin
                if (a == cie_pkg::ST_EVENT && b != STATUS_BAD) ord = ORDER_FIRST;
                if (a == cie_pkg::ST_COMPETING && b == cie_pkg::ST_EVENT) ord = ORDER_SECOND;
            end else begin
                if (a == cie_pkg::ST_EVENT &&
                    (b == cie_pkg::ST_CENSORED || b == cie_pkg::ST_COMPETING))
                    ord = ORDER_FIRST;
                if ((a == cie_pkg::ST_COMPETING || a == cie_pkg::ST_CENSORED) &&
                    b == cie_pkg::ST_EVENT)
                    ord = ORDER_SECOND;
            end
        end
        return ord;
    endfunction

    // Sweep every stored pair and form the counts, ratio and flags
    function automatic t_tally tally_set(input logic [cie_pkg::MODE_W-1:0] mode);
        longint unsigned pairs;
        longint unsigned halves;
        longint unsigned ratio;
        t_tally          t;
        pairs  = 0;
        halves = 0;
        ratio  = 0;
        for (int a = 0; a < set_len; a++) begin
            for (int b = a + 1; b < set_len; b++) begin
                t_risk_order                 ord;
                logic [cie_pkg::SCORE_W-1:0] hi;
                logic [cie_pkg::SCORE_W-1:0] lo;
                ord = rank_pair(mode, set_status[a], set_status[b],
                                set_stamp[a] < set_stamp[b]);
                if (ord != ORDER_NONE) begin
                    pairs++;
                    hi = (ord == ORDER_FIRST) ? set_score[a] : set_score[b];
                    lo = (ord == ORDER_FIRST) ? set_score[b] : set_score[a];
                    if (hi > lo) halves += 2;
                    else if (hi == lo) halves += 1;
                end
            end
        end
        if (pairs != 0) ratio = (halves * 65536 + pairs) / (2 * pairs);
        t.pairs    = (pairs > PAIRS_SAT) ? PAIRS_SAT : pairs[cie_pkg::PAIRS_W-1:0];
        t.halves   = (halves > HALVES_SAT) ? HALVES_SAT : halves[cie_pkg::HALVES_W-1:0];
        t.q16      = ratio[cie_pkg::Q16_W-1:0];
        t.no_pairs = (pairs == 0);
        t.ovf      = set_dropped;
        return t;
    endfunction

    // Offer one input transaction, wait for acceptance, then update the prediction
    task automatic feed_item(input t_item it, input bit typed, input t_tally want);
        t_tally got;
        if ($urandom_range(0, 99) < send_idle) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
        end
        in_valid  <= 1'b1;
        in_score  <= it.score;
        in_status <= it.status;
        in_stamp  <= it.stamp;
        in_last   <= it.last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (set_len < cie_pkg::MAX_ITEMS) begin
            set_score[set_len]  = it.score;
            set_status[set_len] = it.status;
            set_stamp[set_len]  = it.stamp;
            set_len++;
        end else begin
            set_dropped = 1'b1;
        end
        if (it.last) begin
            got = tally_set(eng_mode);
            pending_tallies.push_back(typed ? want : got);
            set_len     = 0;
            set_dropped = 1'b0;
        end
    endtask

    // Drop valid, wait until every expected result has arrived, then let the engine go idle
    task automatic settle_engine();
        in_valid <= 1'b0;
        while (pending_tallies.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_mode(input logic [cie_pkg::MODE_W-1:0] m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        eng_mode     = m;
    endtask

    // Build one data set with random content; a few have unsorted times
    task automatic send_random_set(input int n);
        int                         score_kind;
        bit                         broken;
        int                         r;
        t_item                      it;
        logic [cie_pkg::TIME_W-1:0] stamp;
        score_kind = $urandom_range(0, 2);
        broken     = ($urandom_range(0, 9) == 0);
        stamp      = $urandom;
        for (int k = 0; k < n; k++) begin
            case (score_kind)
                0: it.score = $urandom;
                1: it.score = $urandom_range(0, 3);
                default: begin
                    r = $urandom_range(0, 2);
                    it.score = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
                end
            endcase
            r = $urandom_range(0, 19);
            it.status = (r == 0) ? STATUS_BAD : cie_pkg::STATUS_W'(r % 3);
            if (broken) stamp = $urandom;
            else if ($urandom_range(0, 1) != 0) stamp = stamp + $urandom_range(0, 2);
            else stamp = stamp + $urandom_range(0, 5000);
            it.stamp = stamp;
            it.last  = (k == n - 1);
            feed_item(it, 1'b0, '0);
        end
    endtask

    // Receiver: random back-pressure, plus a long hold-off when asked
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req != hold_ack) begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // Check each accepted result transaction against the oldest expectation
    always @(posedge clk) begin
        t_tally exp_t;
        if (rst_n && out_valid && out_ready) begin
            if (pending_tallies.size() == 0) begin
                $error("result transaction with no expectation waiting");
                mismatches++;
            end else begin
                exp_t = pending_tallies.pop_front();
                if (out_pairs !== exp_t.pairs) begin
                    $error("pair_count: expected %0d, got %0d", exp_t.pairs, out_pairs);
                    mismatches++;
                end
                if (out_halves !== exp_t.halves) begin
                    $error("concordant_halves: expected %0d, got %0d", exp_t.halves,
                           out_halves);
                    mismatches++;
                end
                if (out_q16 !== exp_t.q16) begin
                    $error("concordance_q16: expected %0d, got %0d", exp_t.q16, out_q16);
                    mismatches++;
                end
                if (out_no_pairs !== exp_t.no_pairs) begin
                    $error("no_pairs: expected %0d, got %0d", exp_t.no_pairs, out_no_pairs);
                    mismatches++;
                end
                if (out_ovf !== exp_t.ovf) begin
                    $error("overflowed: expected %0d, got %0d", exp_t.ovf, out_ovf);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random sets under three idling profiles
    initial begin
        logic [cie_pkg::MODE_W-1:0] batch_modes [5];
        bit                         set_open;
        int                         n;
        int                         sets;
        batch_modes = '{cie_pkg::MODE_SURVIVAL, cie_pkg::MODE_COMPETING,
                        cie_pkg::MODE_BINARY, MODE_UNUSED, cie_pkg::MODE_COMPETING};
        // mode, {score, status, time, last}, typed, {pairs, halves, q16, no_pairs, ovf}
        directed_rows = '{
            '{cie_pkg::MODE_BINARY, '{32'h0, cie_pkg::ST_CENSORED, 32'h0, 1'b1}, 1'b1,
              '{19'd0, 20'd0, 17'd0, 1'b1, 1'b0}},
            '{cie_pkg::MODE_BINARY,
              '{32'hFFFF_FFFF, cie_pkg::ST_EVENT, 32'hFFFF_FFFF, 1'b0}, 1'b0, '0},
            '{cie_pkg::MODE_BINARY, '{32'h0, cie_pkg::ST_CENSORED, 32'h0, 1'b1}, 1'b1,
              '{19'd1, 20'd2, 17'd65536, 1'b0, 1'b0}},
            '{cie_pkg::MODE_BINARY, '{32'd5, cie_pkg::ST_CENSORED, 32'd7, 1'b0}, 1'b0, '0},
            '{cie_pkg::MODE_BINARY, '{32'd5, cie_pkg::ST_EVENT, 32'd7, 1'b1}, 1'b1,
              '{19'd1, 20'd1, 17'd32768, 1'b0, 1'b0}},
            '{cie_pkg::MODE_BINARY, '{32'h0, cie_pkg::ST_EVENT, 32'd3, 1'b0}, 1'b0, '0},
            '{cie_pkg::MODE_BINARY,
              '{32'hFFFF_FFFF, cie_pkg::ST_CENSORED, 32'd9, 1'b1}, 1'b1,
              '{19'd1, 20'd0, 17'd0, 1'b0, 1'b0}},
            '{cie_pkg::MODE_SURVIVAL, '{32'd100, cie_pkg::ST_EVENT, 32'd10, 1'b0}, 1'b0, '0},
            '{cie_pkg::MODE_SURVIVAL, '{32'd50, cie_pkg::ST_EVENT, 32'd20, 1'b0}, 1'b0, '0},
            '{cie_pkg::MODE_SURVIVAL, '{32'd70, cie_pkg::ST_CENSORED, 32'd20, 1'b1}, 1'b0, '0},
            '{cie_pkg::MODE_SURVIVAL, '{32'd10, cie_pkg::ST_CENSORED, 32'd50, 1'b0}, 1'b0, '0},
            '{cie_pkg::MODE_SURVIVAL, '{32'd20, cie_pkg::ST_EVENT, 32'd40, 1'b1}, 1'b0, '0},
            '{cie_pkg::MODE_SURVIVAL, '{32'd1, STATUS_BAD, 32'd0, 1'b0}, 1'b0, '0},
            '{cie_pkg::MODE_SURVIVAL, '{32'd2, cie_pkg::ST_EVENT, 32'd5, 1'b1}, 1'b1,
              '{19'd0, 20'd0, 17'd0, 1'b1, 1'b0}},
            '{cie_pkg::MODE_COMPETING, '{32'd10, cie_pkg::ST_COMPETING, 32'd1, 1'b0}, 1'b0, '0},
            '{cie_pkg::MODE_COMPETING, '{32'd20, cie_pkg::ST_EVENT, 32'd2, 1'b0}, 1'b0, '0},
            '{cie_pkg::MODE_COMPETING, '{32'd30, cie_pkg::ST_EVENT, 32'd2, 1'b0}, 1'b0, '0},
            '{cie_pkg::MODE_COMPETING, '{32'd5, cie_pkg::ST_CENSORED, 32'd2, 1'b0}, 1'b0, '0},
            '{cie_pkg::MODE_COMPETING, '{32'd7, cie_pkg::ST_COMPETING, 32'd2, 1'b1}, 1'b0, '0},
            '{MODE_UNUSED, '{32'd1, cie_pkg::ST_EVENT, 32'd0, 1'b0}, 1'b0, '0},
            '{MODE_UNUSED, '{32'd0, cie_pkg::ST_CENSORED, 32'd1, 1'b1}, 1'b1,
              '{19'd0, 20'd0, 17'd0, 1'b1, 1'b0}}
        };

        // Hold reset from time zero, then release
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; change the mode only between sets
        send_idle = 34;
        recv_idle = 87;
        set_open  = 1'b0;
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (!set_open && directed_rows[r].mode != eng_mode) begin
                settle_engine();
                program_mode(directed_rows[r].mode);
            end
            feed_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
            set_open = !directed_rows[r].item.last;
        end

        // Random sets: receiver-heavy idling, sender-heavy idling, then none
        for (int prof = 0; prof < 3; prof++) begin
            send_idle = (prof == 0) ? 34 : (prof == 1) ? 87 : 0;
            recv_idle = (prof == 0) ? 87 : (prof == 1) ? 34 : 0;
            for (int batch = 0; batch < 5; batch++) begin
                settle_engine();
                program_mode(batch_modes[batch]);
                sets = 1;
                if (prof == 2 && batch == 1) send_random_set(BIG_SET_ITEMS);
                if (prof == 2 && batch == 4) begin
                    hold_req <= hold_req + 1;
                    sets = HOLD_SETS;
                end
                repeat (sets) begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 12);
                    send_random_set(n);
                end
            end
        end

        settle_engine();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
